// ----- hw/rtl/gc3_pkg.sv -----
// Shared types, constants and the ambiguity weight table for the GC3 counter.
// Used by every module of the block; has no dependencies.
package gc3_pkg;

   localparam int MAX_SEQ_LEN_DEF = 65536;

   localparam int BASE_W  = 5;
   localparam int GC_W    = 17;
   localparam int TOTAL_W = 15;
   localparam int FRAC_W  = 17;

   // divider geometry: dividend is gc << 16, divisor is 6 * total
   localparam int FRAC_SHIFT = 16;
   localparam int NUM_W      = GC_W + FRAC_SHIFT;
   localparam int DVSR_W     = TOTAL_W + 3;
   localparam int CNT_W      = 6;
   localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1 << FRAC_SHIFT);

   // register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_IGNORE_UNRESOLVED = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IGNORE_GAP        = 1'b1;

   // nucleotide codes
   localparam logic [3:0] CODE_T = 4'd3;

   typedef struct packed {
      logic [GC_W-1:0]    gc;
      logic [TOTAL_W-1:0] total;
   } sums_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // GC weight in sixths for codes 0..15
   function automatic logic [2:0] weight_sixths(logic [3:0] code);
      logic [2:0] w;
      unique case (code)
         4'd0:  w = 3'd0;  // A
         4'd1:  w = 3'd6;  // C
         4'd2:  w = 3'd6;  // G
         4'd3:  w = 3'd0;  // T
         4'd4:  w = 3'd3;  // M
         4'd5:  w = 3'd3;  // R
         4'd6:  w = 3'd3;  // Y
         4'd7:  w = 3'd6;  // S
         4'd8:  w = 3'd0;  // W
         4'd9:  w = 3'd3;  // K
         4'd10: w = 3'd4;  // V
         4'd11: w = 3'd2;  // H
         4'd12: w = 3'd2;  // D
         4'd13: w = 3'd4;  // B
         4'd14: w = 3'd3;  // N
         default: w = 3'd0;
      endcase
      return w;
   endfunction

endpackage

// ----- hw/rtl/gc3_accum.sv -----
// Codon phase tracking and saturating GC / total accumulators.
// Depends on gc3_pkg.
module gc3_accum #(
   parameter int MAX_SEQ_LEN = gc3_pkg::MAX_SEQ_LEN_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        enable,
   input  logic [gc3_pkg::BASE_W-1:0]  base_code,
   input  logic                        last_base,
   input  logic                        ignore_unresolved,
   input  logic                        ignore_gap,
   output gc3_pkg::sums_type           sums_next
);

   localparam longint TOTAL_RAW   = longint'(MAX_SEQ_LEN) / 3;
   localparam longint TOTAL_LIM_L = (TOTAL_RAW > 32767) ? 32767 : TOTAL_RAW;
   localparam longint GC_RAW      = TOTAL_LIM_L * 6;
   localparam longint GC_LIM_L    = (GC_RAW > 131071) ? 131071 : GC_RAW;
   localparam logic [gc3_pkg::TOTAL_W-1:0] TOTAL_LIMIT = gc3_pkg::TOTAL_W'(TOTAL_LIM_L);
   localparam logic [gc3_pkg::GC_W:0]      GC_LIMIT    = (gc3_pkg::GC_W + 1)'(GC_LIM_L);
   localparam logic [gc3_pkg::TOTAL_W-1:0] TOTAL_ONE   = gc3_pkg::TOTAL_W'(1);

   logic [1:0]                  phase_ff, phase_in;
   logic [gc3_pkg::GC_W-1:0]    gc_ff, gc_in;
   logic [gc3_pkg::TOTAL_W-1:0] total_ff, total_in;

   logic       count_it;
   logic [2:0] weight;
   logic [gc3_pkg::GC_W:0] gc_sum;

   always_comb begin
      count_it = 1'b0;
      weight   = gc3_pkg::weight_sixths(base_code[3:0]);
      if (phase_ff == 2'd2) begin
         phase_in = 2'd0;
         if (base_code[4]) begin
            // any negative code is a gap: total only
            count_it = ~ignore_gap;
            weight   = 3'd0;
         end else if (base_code[3:0] <= gc3_pkg::CODE_T) begin
            count_it = 1'b1;
         end else begin
            count_it = ~ignore_unresolved;
         end
      end else begin
         phase_in = phase_ff + 2'd1;
      end

      gc_sum   = {1'b0, gc_ff} + (gc3_pkg::GC_W + 1)'(weight);
      gc_in    = gc_ff;
      total_in = total_ff;
      if (count_it) begin
         if (total_ff < TOTAL_LIMIT) total_in = total_ff + TOTAL_ONE;
         gc_in = (gc_sum > GC_LIMIT) ? GC_LIMIT[gc3_pkg::GC_W-1:0]
                                     : gc_sum[gc3_pkg::GC_W-1:0];
      end
   end

   assign sums_next.gc    = gc_in;
   assign sums_next.total = total_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         gc_ff    <= '0;
         total_ff <= '0;
      end else if (enable) begin
         if (last_base) begin
            phase_ff <= '0;
            gc_ff    <= '0;
            total_ff <= '0;
         end else begin
            phase_ff <= phase_in;
            gc_ff    <= gc_in;
            total_ff <= total_in;
         end
      end
   end

endmodule

// ----- hw/rtl/gc3_divider.sv -----
// Restoring divider, one quotient bit per cycle: (gc << 16) / (6 * total).
// Depends on gc3_pkg. Holds its result until taken.
module gc3_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  gc3_pkg::sums_type             sums,
   input  logic                          take,
   output gc3_pkg::div_status_type       status,
   output logic [gc3_pkg::FRAC_W-1:0]    fraction
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;
   localparam logic [gc3_pkg::CNT_W-1:0] LAST_STEP = gc3_pkg::CNT_W'(gc3_pkg::NUM_W - 1);
   localparam logic [gc3_pkg::CNT_W-1:0] CNT_ONE   = gc3_pkg::CNT_W'(1);

   logic [1:0]                   state_ff, state_in;
   logic [gc3_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic [gc3_pkg::NUM_W-1:0]    num_ff, num_in;    // dividend in, quotient out
   logic [gc3_pkg::DVSR_W-1:0]   dvsr_ff, dvsr_in;
   logic [gc3_pkg::DVSR_W-1:0]   rem_ff, rem_in;
   logic                         zero_ff, zero_in;

   logic [gc3_pkg::DVSR_W:0] rem_shift;
   logic [gc3_pkg::DVSR_W:0] diff;
   logic                     ge;

   always_comb begin
      rem_shift = {rem_ff, num_ff[gc3_pkg::NUM_W-1]};
      diff      = rem_shift - {1'b0, dvsr_ff};
      ge        = rem_shift >= {1'b0, dvsr_ff};

      state_in = state_ff;
      cnt_in   = cnt_ff;
      num_in   = num_ff;
      dvsr_in  = dvsr_ff;
      rem_in   = rem_ff;
      zero_in  = zero_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_RUN;
               cnt_in   = LAST_STEP;
               num_in   = {sums.gc, gc3_pkg::FRAC_SHIFT'(0)};
               // 6 * total as 4 * total + 2 * total
               dvsr_in  = {1'b0, sums.total, 2'b00} + {2'b00, sums.total, 1'b0};
               rem_in   = '0;
               zero_in  = (sums.total == '0);
            end
         end
         ST_RUN: begin
            rem_in = ge ? diff[gc3_pkg::DVSR_W-1:0] : rem_shift[gc3_pkg::DVSR_W-1:0];
            num_in = {num_ff[gc3_pkg::NUM_W-2:0], ge};
            cnt_in = cnt_ff - CNT_ONE;
            if (cnt_ff == '0) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (take) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff  <= cnt_in;
      num_ff  <= num_in;
      dvsr_ff <= dvsr_in;
      rem_ff  <= rem_in;
      zero_ff <= zero_in;
   end

   assign status.busy = (state_ff != ST_IDLE);
   assign status.done = (state_ff == ST_DONE);

   always_comb begin
      if (zero_ff) begin
         fraction = '0;
      end else if (num_ff > gc3_pkg::NUM_W'(gc3_pkg::FRAC_ONE)) begin
         fraction = gc3_pkg::FRAC_ONE;
      end else begin
         fraction = num_ff[gc3_pkg::FRAC_W-1:0];
      end
   end

endmodule

// ----- hw/rtl/gc3_content_counter.sv -----
// GC3 content counter: top level with configuration registers, sequencing and
// the result register. Depends on gc3_pkg, gc3_accum and gc3_divider.
//
// Streams a DNA sequence one base code per item and counts only the third base
// of each complete codon. G/C add a full unit of GC weight, A/T none; ambiguity
// codes (when ignore_unresolved is 0) add a fractional weight kept exactly in
// sixths, and gaps (when ignore_gap is 0) add to the total only. An item that is
// not marked last leaves req_stall low. An item marked last is folded into the
// sums in its accept cycle and then starts the restoring divider, which
// produces one quotient bit per cycle; the result waits in the divider's done
// state until the output register is free and is then copied into it, and no
// next item is taken before that (so it waits while the previous result is
// still held by rsp_stall). The divider is the only multi-cycle unit.
// The result gives gc_fraction = gc_sum_sixths / (6 * counted_positions) as
// unsigned Q1.16, truncated, or 0 when nothing was counted; the sequence sums
// then restart from zero. Counts saturate at MAX_SEQ_LEN/3 positions (at most
// 32767). Configuration writes are taken at any time but should only be made
// while the block is idle.
module gc3_content_counter #(
   parameter int MAX_SEQ_LEN = gc3_pkg::MAX_SEQ_LEN_DEF
) (
   input  logic                           clock,
   input  logic                           reset,

   // input items
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [gc3_pkg::BASE_W-1:0] req_base_code,
   input  logic                           req_last_base,

   // result items
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [gc3_pkg::FRAC_W-1:0]     rsp_gc_fraction,
   output logic [gc3_pkg::GC_W-1:0]       rsp_gc_sum_sixths,
   output logic [gc3_pkg::TOTAL_W-1:0]    rsp_counted_positions,

   // configuration writes
   input  logic                           csr_wen,
   input  logic [gc3_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic                           csr_wdata
);

   logic ignore_unresolved_ff, ignore_unresolved_in;
   logic ignore_gap_ff, ignore_gap_in;

   logic req_accept;
   logic div_start;
   logic div_take;
   logic out_free;

   gc3_pkg::sums_type       sums_next;
   gc3_pkg::sums_type       hold_ff, hold_in;
   gc3_pkg::div_status_type div_status;
   logic [gc3_pkg::FRAC_W-1:0] div_fraction;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [gc3_pkg::FRAC_W-1:0]    frac_ff, frac_in;
   logic [gc3_pkg::GC_W-1:0]      gc_out_ff, gc_out_in;
   logic [gc3_pkg::TOTAL_W-1:0]   total_out_ff, total_out_in;

   // no new item while a final division runs or its result waits
   assign req_stall  = div_status.busy;
   assign req_accept = req_valid & ~req_stall;
   assign div_start  = req_accept & req_last_base;

   // result register is free when empty or being drained this cycle
   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign div_take = div_status.done & out_free;

   // configuration registers
   always_comb begin
      ignore_unresolved_in = ignore_unresolved_ff;
      ignore_gap_in        = ignore_gap_ff;
      if (csr_wen) begin
         unique case (csr_index)
            gc3_pkg::CSR_IGNORE_UNRESOLVED: ignore_unresolved_in = csr_wdata;
            gc3_pkg::CSR_IGNORE_GAP:        ignore_gap_in        = csr_wdata;
            default: ;
         endcase
      end
   end

   gc3_accum #(
      .MAX_SEQ_LEN(MAX_SEQ_LEN)
   ) u_accum (
      .clock             (clock),
      .reset             (reset),
      .enable            (req_accept),
      .base_code         (req_base_code),
      .last_base         (req_last_base),
      .ignore_unresolved (ignore_unresolved_ff),
      .ignore_gap        (ignore_gap_ff),
      .sums_next         (sums_next)
   );

   gc3_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .sums     (sums_next),
      .take     (div_take),
      .status   (div_status),
      .fraction (div_fraction)
   );

   // final sums kept alongside the division
   assign hold_in = div_start ? sums_next : hold_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      frac_in      = frac_ff;
      gc_out_in    = gc_out_ff;
      total_out_in = total_out_ff;
      if (div_take) begin
         rsp_valid_in = 1'b1;
         frac_in      = div_fraction;
         gc_out_in    = hold_ff.gc;
         total_out_in = hold_ff.total;
      end else if (~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ignore_unresolved_ff <= 1'b1;
         ignore_gap_ff        <= 1'b1;
         rsp_valid_ff         <= 1'b0;
      end else begin
         ignore_unresolved_ff <= ignore_unresolved_in;
         ignore_gap_ff        <= ignore_gap_in;
         rsp_valid_ff         <= rsp_valid_in;
      end
      hold_ff      <= hold_in;
      frac_ff      <= frac_in;
      gc_out_ff    <= gc_out_in;
      total_out_ff <= total_out_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_gc_fraction       = frac_ff;
   assign rsp_gc_sum_sixths     = gc_out_ff;
   assign rsp_counted_positions = total_out_ff;

endmodule

// ----- bench/gc3_content_counter_tb.sv -----
// Self-checking bench for gc3_content_counter: directed table, then random
// sequences under random idling. Needs gc3_pkg and gc3_content_counter.
module gc3_content_counter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // nucleotide codes as driven on req_base_code
   localparam logic signed [gc3_pkg::BASE_W-1:0] NT_A       = 5'sd0;
   localparam logic signed [gc3_pkg::BASE_W-1:0] NT_C       = 5'sd1;
   localparam logic signed [gc3_pkg::BASE_W-1:0] NT_G       = 5'sd2;
   localparam logic signed [gc3_pkg::BASE_W-1:0] NT_T       = 5'sd3;
   localparam logic signed [gc3_pkg::BASE_W-1:0] NT_M       = 5'sd4;
   localparam logic signed [gc3_pkg::BASE_W-1:0] NT_S       = 5'sd7;
   localparam logic signed [gc3_pkg::BASE_W-1:0] NT_H       = 5'sd11;
   localparam logic signed [gc3_pkg::BASE_W-1:0] NT_UNUSED  = 5'sd15;
   localparam logic signed [gc3_pkg::BASE_W-1:0] NT_GAP     = -5'sd1;
   localparam logic signed [gc3_pkg::BASE_W-1:0] NT_NEG_MIN = -5'sd16;

   // GC weight in sixths, indexed by the low four code bits (15 down to 0)
   localparam logic [15:0][2:0] GC_SIXTHS = {
      3'd0, 3'd3, 3'd4, 3'd2, 3'd2, 3'd4, 3'd3, 3'd0,
      3'd6, 3'd3, 3'd3, 3'd3, 3'd0, 3'd6, 3'd6, 3'd0
   };

   localparam int SEQ_LEN_MAX  = gc3_pkg::MAX_SEQ_LEN_DEF;
   localparam int POS_LIMIT    = (SEQ_LEN_MAX / 3 > 32767) ? 32767 : SEQ_LEN_MAX / 3;
   localparam int GC_SUM_LIMIT = (POS_LIMIT * 6 > 131071) ? 131071 : POS_LIMIT * 6;
   localparam int THIRD_POS    = 2;

   localparam int RANDOM_ITEMS     = 1550;
   localparam int SETTLE_CYCLES    = 40;               // divider pass plus result register
   localparam int LONG_HOLD_CYCLES = 500;
   // worst quiet stretch: long hold + divider + longest gaps, with margin
   localparam int QUIET_LIMIT      = 4000;

   typedef struct packed {
      logic [gc3_pkg::FRAC_W-1:0]  frac;
      logic [gc3_pkg::GC_W-1:0]    gc;
      logic [gc3_pkg::TOTAL_W-1:0] pos;
   } seq_result_type;

   typedef struct packed {
      bit                                 is_cfg;
      bit                                 cfg_unres;
      bit                                 cfg_gap;
      logic signed [gc3_pkg::BASE_W-1:0]  code;
      bit                                 last;
      bit                                 typed;
      seq_result_type                     known;
   } plan_row_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic signed [gc3_pkg::BASE_W-1:0] req_base_code = '0;
   logic                              req_last_base = 1'b0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic [gc3_pkg::FRAC_W-1:0]        rsp_gc_fraction;
   logic [gc3_pkg::GC_W-1:0]          rsp_gc_sum_sixths;
   logic [gc3_pkg::TOTAL_W-1:0]       rsp_counted_positions;
   logic                              csr_wen = 1'b0;
   logic [gc3_pkg::CSR_IDX_W-1:0]     csr_index = '0;
   logic                              csr_wdata = 1'b0;

   // predictor state: codon position, sums, and its copy of the registers
   int          codon_pos = 0;
   int          gc_sum = 0;
   int          pos_count = 0;
   bit          skip_unresolved = 1'b1;
   bit          skip_gaps = 1'b1;

   seq_result_type expected_seq_results[$];
   plan_row_type   plan[$];
   int             mismatch_count = 0;
   bit             long_hold_pending = 1'b0;

   gc3_content_counter #(
      .MAX_SEQ_LEN(SEQ_LEN_MAX)
   ) u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_base_code         (req_base_code),
      .req_last_base         (req_last_base),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_gc_fraction       (rsp_gc_fraction),
      .rsp_gc_sum_sixths     (rsp_gc_sum_sixths),
      .rsp_counted_positions (rsp_counted_positions),
      .csr_wen               (csr_wen),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   // one counted third position: total clamps first, GC sum clamps on its own
   function automatic void count_third(int sixths);
      if (pos_count < POS_LIMIT) pos_count++;
      gc_sum += sixths;
      if (gc_sum > GC_SUM_LIMIT) gc_sum = GC_SUM_LIMIT;
   endfunction

   // advances the sequence state by one base; returns 1 with the result on last
   function automatic bit predict_gc3(logic signed [gc3_pkg::BASE_W-1:0] code, bit last,
                                      output seq_result_type res);
      logic [gc3_pkg::BASE_W-1:0] raw;
      longint                     q;
      raw = code;
      res = '0;
      if (codon_pos == THIRD_POS) begin
         codon_pos = 0;
         if (raw[gc3_pkg::BASE_W-1]) begin
            // any negative code is a gap: total only, never GC
            if (!skip_gaps) count_third(0);
         end else if (code <= NT_T) begin
            count_third(GC_SIXTHS[raw[3:0]]);
         end else if (!skip_unresolved) begin
            // ambiguity codes, code fifteen weighs nothing
            count_third(GC_SIXTHS[raw[3:0]]);
         end
      end else begin
         codon_pos++;
      end
      if (!last) return 1'b0;
      q = 0;
      if (pos_count != 0) begin
         q = (longint'(gc_sum) << gc3_pkg::FRAC_SHIFT) / (6 * longint'(pos_count));
         if (q > longint'(gc3_pkg::FRAC_ONE)) q = longint'(gc3_pkg::FRAC_ONE);
      end
      res.frac  = gc3_pkg::FRAC_W'(q);
      res.gc    = gc3_pkg::GC_W'(gc_sum);
      res.pos   = gc3_pkg::TOTAL_W'(pos_count);
      codon_pos = 0;
      gc_sum    = 0;
      pos_count = 0;
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------- helpers

   function automatic void plan_append(plan_row_type row);
      plan.insert(plan.size(), row);
   endfunction

   function automatic void expect_result(seq_result_type res);
      expected_seq_results.insert(expected_seq_results.size(), res);
   endfunction

   // mostly back-to-back, some short gaps, a few long ones
   function automatic int idle_span(bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [gc3_pkg::BASE_W-1:0] random_code();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return gc3_pkg::BASE_W'($urandom_range(NT_A, NT_T));
      if (r < 75) return gc3_pkg::BASE_W'($urandom_range(NT_M, NT_UNUSED));
      if (r < 88) return NT_GAP;
      return gc3_pkg::BASE_W'($urandom_range(0, 31));   // whole field, other negatives too
   endfunction

   function automatic void add_base(logic signed [gc3_pkg::BASE_W-1:0] code,
                                    bit last = 1'b0, bit typed = 1'b0, int frac = 0,
                                    int gc = 0, int pos = 0);
      plan_row_type row;
      row            = '0;
      row.code       = code;
      row.last       = last;
      row.typed      = typed;
      row.known.frac = gc3_pkg::FRAC_W'(frac);
      row.known.gc   = gc3_pkg::GC_W'(gc);
      row.known.pos  = gc3_pkg::TOTAL_W'(pos);
      plan_append(row);
   endfunction

   function automatic void add_cfg(bit unres, bit gap);
      plan_row_type row;
      row           = '0;
      row.is_cfg    = 1'b1;
      row.cfg_unres = unres;
      row.cfg_gap   = gap;
      plan_append(row);
   endfunction

   task automatic report_mismatch(string msg);
      mismatch_count++;
      $display("%0t mismatch: %s", $realtime, msg);
   endtask

   task automatic check_field(string name, int got, int want);
      if (got != want)
         report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   // offers one item and holds it until taken; valid stays up for a follow-on
   task automatic send_base(logic signed [gc3_pkg::BASE_W-1:0] code, bit last, bit calm);
      int             gap;
      seq_result_type res;
      gap = idle_span(calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_base_code <= code;
      req_last_base <= last;
      do @(posedge clock); while (req_stall);
      if (predict_gc3(code, last, res)) expect_result(res);
   endtask

   // registers change only with the block drained and the divider quiet
   task automatic set_config(bit unres, bit gap);
      req_valid <= 1'b0;
      while (expected_seq_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= gc3_pkg::CSR_IGNORE_UNRESOLVED;
      csr_wdata <= unres;
      @(posedge clock);
      csr_index <= gc3_pkg::CSR_IGNORE_GAP;
      csr_wdata <= gap;
      @(posedge clock);
      csr_wen         <= 1'b0;
      skip_unresolved = unres;
      skip_gaps       = gap;
   endtask

   // ---------------------------------------------------------------- checking

   always @(posedge clock) begin : result_check
      seq_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_seq_results.size() == 0) begin
            report_mismatch("result item with nothing expected");
         end else begin
            want = expected_seq_results.pop_front();
            check_field("gc_fraction", rsp_gc_fraction, want.frac);
            check_field("gc_sum_sixths", rsp_gc_sum_sixths, want.gc);
            check_field("counted_positions", rsp_counted_positions, want.pos);
         end
      end
   end

   // ends the run when nothing moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wen)
            quiet = 0;
         else
            quiet++;
      end
      $display("gc3_content_counter_tb: errors");
      $finish;
   end

   // receiver: random stall spans, calm stretches, and one long hold on request
   initial begin : result_side
      int span;
      int mood_left;
      bit calm;
      mood_left = 0;
      calm      = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_pending) begin
            // block fills up behind the held result and must stall its input
            long_hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end
         if (mood_left == 0) begin
            calm      = ($urandom_range(0, 3) == 0);
            mood_left = $urandom_range(10, 80);
         end
         mood_left--;
         span = idle_span(calm);
         if (span > 0) begin
            rsp_stall <= 1'b1;
            repeat (span) @(posedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   // ---------------------------------------------------------------- stimulus

   initial begin : stimulus
      int rand_items;
      int seq_idx;
      int len;
      int r;
      bit calm;

      // directed table; registers start at reset (both skips set)
      add_base(NT_G, 1'b1, 1'b1, 0, 0, 0);              // lone base, no codon
      add_base(NT_C);
      add_base(NT_A);
      add_base(NT_G, 1'b1, 1'b1, gc3_pkg::FRAC_ONE, 6, 1);  // full GC, fraction one
      add_base(NT_A);
      add_base(NT_A);
      add_base(NT_S);                                   // ambiguity skipped
      add_base(NT_A);
      add_base(NT_A);
      add_base(NT_GAP);                                 // gap skipped
      add_base(NT_G);
      add_base(NT_G, 1'b1, 1'b1, 0, 0, 0);              // trailing partial codon
      add_cfg(1'b0, 1'b0);
      add_base(NT_A);
      add_base(NT_A);
      add_base(NT_NEG_MIN);                             // most negative code is a gap
      add_base(NT_A);
      add_base(NT_A);
      add_base(NT_UNUSED);                              // code fifteen, weight zero
      add_base(NT_A);
      add_base(NT_A);
      add_base(NT_H, 1'b1);
      add_base(NT_A);
      add_base(NT_A);
      add_base(NT_T, 1'b1, 1'b1, 0, 0, 1);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[k]) begin
         if (plan[k].is_cfg) begin
            set_config(plan[k].cfg_unres, plan[k].cfg_gap);
         end else begin
            send_base(plan[k].code, plan[k].last, 1'b0);
            if (plan[k].last && plan[k].typed)
               expected_seq_results[$] = plan[k].known;
         end
      end

      // random sequences; all four register settings first, then random ones
      rand_items = 0;
      seq_idx    = 0;
      while (rand_items < RANDOM_ITEMS) begin
         if (seq_idx % 10 == 0) begin
            if (seq_idx / 10 < 4)
               set_config(seq_idx / 10 % 2 == 1, seq_idx / 20 == 1);
            else
               set_config($urandom_range(0, 1), $urandom_range(0, 1));
         end
         if (seq_idx == 3) long_hold_pending = 1'b1;
         r = $urandom_range(0, 99);
         if (r < 10)      len = $urandom_range(1, 2);
         else if (r < 80) len = $urandom_range(3, 30);
         else if (r < 95) len = $urandom_range(31, 120);
         else             len = $urandom_range(121, 400);
         calm = ($urandom_range(0, 3) == 0);
         if (seq_idx == 3 || seq_idx == 4) begin
            // short back-to-back sequences so results pile up behind the hold
            len  = $urandom_range(3, 12);
            calm = 1'b1;
         end
         for (int i = 0; i < len; i++)
            send_base(random_code(), i == len - 1, calm);
         rand_items += len;
         seq_idx++;
      end

      req_valid <= 1'b0;
      while (expected_seq_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("gc3_content_counter_tb: clean");
      else
         $display("gc3_content_counter_tb: errors");
      $finish;
   end

endmodule
